### src/p2c_pkg.sv
// ----------------------------------------------------------------------------
// p2c_pkg: shared types and constants for the scan polar to cartesian unit
// Fixed-point formats, CORDIC constants and the beat sideband carried along
// the pipeline.
// ----------------------------------------------------------------------------
package p2c_pkg;

    localparam int COEF_FRAC_BITS = 14;
    localparam int CORDIC_STAGES  = 16;

    // CORDIC datapath: Q2.30 x/y, 32-bit turn angle residue
    localparam int CW = 32;
    localparam logic signed [CW-1:0] CORDIC_ONE_K = 32'sd652032874;

    localparam logic signed [CW-1:0] ATAN_TURNS [24] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    // sensor-frame point: mm with 16 fraction bits
    localparam int RNG_W  = 17;
    localparam int PROD_W = RNG_W + 1 + CW;
    localparam int PX_SH  = 14;
    localparam int PX_W   = PROD_W - PX_SH;

    // row transform accumulator
    localparam int K_W    = 16;
    localparam int SH     = COEF_FRAC_BITS + 16;
    localparam int KP_W   = K_W + PX_W;
    localparam int ACC_W  = KP_W + 4;
    localparam int V_W    = ACC_W - SH;
    localparam int OUT_W  = 20;

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 3'd4;

    localparam logic [63:0] ROW_X_RST = 64'h4000_0000_0000_0000;
    localparam logic [63:0] ROW_Y_RST = 64'h0000_4000_0000_0000;
    localparam logic [63:0] ROW_Z_RST = 64'h0000_0000_4000_0000;
    localparam logic [15:0] START_ANGLE_RST = 16'd64626;
    localparam logic [15:0] ANGLE_STEP_RST  = 16'd91;

    typedef struct packed {
        logic             valid;
        logic [RNG_W-1:0] range_mm;
        logic [15:0]      intensity;
        logic             last;
        logic [1:0]       quad;
    } t_meta;

endpackage

### src/p2c_cordic_cell.sv
// ----------------------------------------------------------------------------
// p2c_cordic_cell: one CORDIC rotation step
// Takes x/y/z and the beat sideband from its left neighbor and registers one
// micro-rotation toward z = 0.
// ----------------------------------------------------------------------------
module p2c_cordic_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic [4:0]                      i_shift,
    input  logic signed [p2c_pkg::CW-1:0]   i_atan,
    input  logic signed [p2c_pkg::CW-1:0]   i_x,
    input  logic signed [p2c_pkg::CW-1:0]   i_y,
    input  logic signed [p2c_pkg::CW-1:0]   i_z,
    input  p2c_pkg::t_meta                  i_meta,
    output logic signed [p2c_pkg::CW-1:0]   o_x,
    output logic signed [p2c_pkg::CW-1:0]   o_y,
    output logic signed [p2c_pkg::CW-1:0]   o_z,
    output p2c_pkg::t_meta                  o_meta
);

    logic signed [p2c_pkg::CW-1:0] r_x, r_y, r_z;
    logic signed [p2c_pkg::CW-1:0] n_x, n_y, n_z;
    logic signed [p2c_pkg::CW-1:0] dx, dy;
    p2c_pkg::t_meta                r_meta;

    assign dx = i_y >>> i_shift;
    assign dy = i_x >>> i_shift;

    always_comb begin
        if (!i_z[p2c_pkg::CW-1]) begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - i_atan;
        end else begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + i_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta <= '0;
        end else if (i_en) begin
            r_meta <= i_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_meta = r_meta;

endmodule

### src/p2c_row.sv
// ----------------------------------------------------------------------------
// p2c_row: one row of the rigid transform
// Registers k0*px and k1*py, then adds the offset, rounds to mm and
// saturates to 20 bits signed.
// ----------------------------------------------------------------------------
module p2c_row (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [63:0]                      i_row,
    input  logic signed [p2c_pkg::PX_W-1:0]  i_px,
    input  logic signed [p2c_pkg::PX_W-1:0]  i_py,
    output logic [p2c_pkg::OUT_W-1:0]        o_coord,
    output logic                             o_clip
);

    logic signed [p2c_pkg::K_W-1:0]   k0, k1, off;
    logic signed [p2c_pkg::KP_W-1:0]  r_p0, r_p1;
    logic signed [p2c_pkg::ACC_W-1:0] acc;
    logic signed [p2c_pkg::V_W-1:0]   v;
    logic [p2c_pkg::V_W-p2c_pkg::OUT_W:0] top_bits;

    assign k0  = i_row[63:48];
    assign k1  = i_row[47:32];
    assign off = i_row[15:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= k0 * i_px;
            r_p1 <= k1 * i_py;
        end
    end

    assign acc = p2c_pkg::ACC_W'(r_p0) + p2c_pkg::ACC_W'(r_p1)
               + (p2c_pkg::ACC_W'(off) <<< p2c_pkg::SH)
               + (p2c_pkg::ACC_W'(1) <<< (p2c_pkg::SH - 1));
    assign v   = acc[p2c_pkg::ACC_W-1:p2c_pkg::SH];

    assign top_bits = v[p2c_pkg::V_W-1:p2c_pkg::OUT_W-1];
    assign o_clip   = !((&top_bits) || !(|top_bits));

    always_comb begin
        if (!o_clip) begin
            o_coord = v[p2c_pkg::OUT_W-1:0];
        end else if (v[p2c_pkg::V_W-1]) begin
            o_coord = p2c_pkg::OUT_MIN;
        end else begin
            o_coord = p2c_pkg::OUT_MAX;
        end
    end

endmodule

### src/scan_polar_to_cartesian_transform_unit.sv
// ----------------------------------------------------------------------------
// scan_polar_to_cartesian_transform_unit: scanner beam to vehicle-frame point
// Steps the beam angle, rotates through a chain of CORDIC cells, scales by
// range and applies a configured 3x2 matrix on x/y plus translation.
//
//   channel  valid        ready        payload
//   in       i_in_valid   o_in_ready   i_range_mm i_intensity i_first_beam
//                                      i_last_beam
//   out      o_out_valid  i_out_ready  o_x_mm o_y_mm o_z_mm o_point_intensity
//                                      o_scan_end o_clipped
//   cfg      i_cfg_valid  o_cfg_ready  i_cfg_index i_cfg_data
//
// One beat per cycle unless the output stalls; registered through the CORDIC
// cells, range multiply, row products and output register.
// Synchronous reset restores the default transform (x and y pass through, z is zero) and clears the pipeline valids.
// When the output register holds an unaccepted beat the whole pipeline stalls.
// ----------------------------------------------------------------------------
module scan_polar_to_cartesian_transform_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [16:0]                         i_range_mm,
    input  logic [15:0]                         i_intensity,
    input  logic                                i_first_beam,
    input  logic                                i_last_beam,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [19:0]                  o_x_mm,
    output logic signed [19:0]                  o_y_mm,
    output logic signed [19:0]                  o_z_mm,
    output logic [15:0]                         o_point_intensity,
    output logic                                o_scan_end,
    output logic                                o_clipped,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [p2c_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [63:0]                         i_cfg_data
);

    localparam int N = p2c_pkg::CORDIC_STAGES;

    logic [63:0] r_row_x, r_row_y, r_row_z;
    logic [15:0] r_start_angle, r_angle_step;
    logic [15:0] r_angle, n_angle;
    logic        en, accept;

    logic signed [p2c_pkg::CW-1:0] w_x [0:N];
    logic signed [p2c_pkg::CW-1:0] w_y [0:N];
    logic signed [p2c_pkg::CW-1:0] w_z [0:N];
    p2c_pkg::t_meta                w_meta [0:N];

    logic signed [p2c_pkg::CW-1:0]     c, s;
    logic signed [p2c_pkg::PROD_W-1:0] prod_c, prod_s, rnd_c, rnd_s;
    logic signed [p2c_pkg::RNG_W:0]    rng_s;
    logic signed [p2c_pkg::PX_W-1:0]   r_px, r_py;
    p2c_pkg::t_meta                    r_meta_px, r_meta_prod;

    logic [p2c_pkg::OUT_W-1:0] cx, cy, cz;
    logic                      clx, cly, clz;

    logic                      r_out_valid;
    logic [p2c_pkg::OUT_W-1:0] r_x, r_y, r_z;
    logic [15:0]               r_inten;
    logic                      r_last, r_clip;

    assign en          = !r_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign accept      = i_in_valid && en;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x       <= p2c_pkg::ROW_X_RST;
            r_row_y       <= p2c_pkg::ROW_Y_RST;
            r_row_z       <= p2c_pkg::ROW_Z_RST;
            r_start_angle <= p2c_pkg::START_ANGLE_RST;
            r_angle_step  <= p2c_pkg::ANGLE_STEP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                p2c_pkg::REG_ROW_X:       r_row_x       <= i_cfg_data;
                p2c_pkg::REG_ROW_Y:       r_row_y       <= i_cfg_data;
                p2c_pkg::REG_ROW_Z:       r_row_z       <= i_cfg_data;
                p2c_pkg::REG_START_ANGLE: r_start_angle <= i_cfg_data[15:0];
                p2c_pkg::REG_ANGLE_STEP:  r_angle_step  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // beam angle
    assign n_angle = i_first_beam ? r_start_angle : r_angle + r_angle_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
        end else if (accept) begin
            r_angle <= n_angle;
        end
    end

    // feed of the cell chain
    assign w_x[0] = p2c_pkg::CORDIC_ONE_K;
    assign w_y[0] = '0;
    assign w_z[0] = {2'b00, n_angle[13:0], 16'h0000};
    assign w_meta[0] = '{valid:     accept,
                         range_mm:  i_range_mm,
                         intensity: i_intensity,
                         last:      i_last_beam,
                         quad:      n_angle[15:14]};

    for (genvar g = 0; g < N; g++) begin : g_cell
        p2c_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_shift (5'(g)),
            .i_atan  (p2c_pkg::ATAN_TURNS[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .i_meta  (w_meta[g]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1]),
            .o_meta  (w_meta[g+1])
        );
    end

    // quadrant fold and range scaling
    always_comb begin
        unique case (w_meta[N].quad)
            2'd0: begin c = w_x[N];  s = w_y[N];  end
            2'd1: begin c = -w_y[N]; s = w_x[N];  end
            2'd2: begin c = -w_x[N]; s = -w_y[N]; end
            default: begin c = w_y[N]; s = -w_x[N]; end
        endcase
    end

    assign rng_s  = {1'b0, w_meta[N].range_mm};
    assign prod_c = rng_s * c;
    assign prod_s = rng_s * s;
    assign rnd_c  = prod_c + (p2c_pkg::PROD_W'(1) <<< (p2c_pkg::PX_SH - 1));
    assign rnd_s  = prod_s + (p2c_pkg::PROD_W'(1) <<< (p2c_pkg::PX_SH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta_px   <= '0;
            r_meta_prod <= '0;
        end else if (en) begin
            r_meta_px   <= w_meta[N];
            r_meta_prod <= r_meta_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px <= rnd_c[p2c_pkg::PROD_W-1:p2c_pkg::PX_SH];
            r_py <= rnd_s[p2c_pkg::PROD_W-1:p2c_pkg::PX_SH];
        end
    end

    // rigid transform rows
    p2c_row u_row_x (
        .i_clk (i_clk), .i_en (en), .i_row (r_row_x),
        .i_px (r_px), .i_py (r_py), .o_coord (cx), .o_clip (clx)
    );
    p2c_row u_row_y (
        .i_clk (i_clk), .i_en (en), .i_row (r_row_y),
        .i_px (r_px), .i_py (r_py), .o_coord (cy), .o_clip (cly)
    );
    p2c_row u_row_z (
        .i_clk (i_clk), .i_en (en), .i_row (r_row_z),
        .i_px (r_px), .i_py (r_py), .o_coord (cz), .o_clip (clz)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_meta_prod.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x     <= cx;
            r_y     <= cy;
            r_z     <= cz;
            r_inten <= r_meta_prod.intensity;
            r_last  <= r_meta_prod.last;
            r_clip  <= clx || cly || clz;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_x_mm            = r_x;
    assign o_y_mm            = r_y;
    assign o_z_mm            = r_z;
    assign o_point_intensity = r_inten;
    assign o_scan_end        = r_last;
    assign o_clipped         = r_clip;

endmodule

### bench/scan_polar_to_cartesian_transform_unit_test.sv
// ----------------------------------------------------------------------------
// scan_polar_to_cartesian_transform_unit_test: self-checking bench
// Feeds scanner beams and register writes through the valid/ready channels
// and computes each vehicle-frame point independently: CORDIC sin/cos, range
// scaling, row transform, rounding and saturation. Each output beat is checked
// field by field against the oldest pending point. Phases vary the transform
// and the idling on both sides, with a long output hold and a full drain.
// ----------------------------------------------------------------------------
module scan_polar_to_cartesian_transform_unit_test;
    import p2c_pkg::*;

    localparam int     LATENCY        = CORDIC_STAGES + 3;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     HOLD_CYCLES    = 300;
    localparam int     RANDOM_PHASES  = 8;
    localparam int     PHASE_BEAMS    = 123;
    localparam longint POINT_MAX      = 524287;
    localparam longint POINT_MIN      = -524288;
    localparam logic [16:0] RANGE_MAX = '1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_ANGLE_STEP + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct {
        logic [16:0] range_mm;
        logic [15:0] intensity;
        logic        first_beam;
        logic        last_beam;
    } t_beam;

    typedef struct {
        logic signed [19:0] x_mm;
        logic signed [19:0] y_mm;
        logic signed [19:0] z_mm;
        logic [15:0]        point_intensity;
        logic               scan_end;
        logic               clipped;
    } t_point;

    class point_scoreboard;
        logic [63:0] rows [3];
        logic [15:0] start_angle;
        logic [15:0] angle_step;
        logic [15:0] beam_angle;
        t_point      expected_points [$];
        int unsigned mismatches;

        function new();
            rows[0]     = ROW_X_RST;
            rows[1]     = ROW_Y_RST;
            rows[2]     = ROW_Z_RST;
            start_angle = START_ANGLE_RST;
            angle_step  = ANGLE_STEP_RST;
            beam_angle  = '0;
            mismatches  = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
            case (idx)
                REG_ROW_X:       rows[0] = data;
                REG_ROW_Y:       rows[1] = data;
                REG_ROW_Z:       rows[2] = data;
                REG_START_ANGLE: start_angle = data[15:0];
                REG_ANGLE_STEP:  angle_step = data[15:0];
                default: ;
            endcase
        endfunction

        function longint round_shift(longint v, int n);
            return (v + (longint'(1) <<< (n - 1))) >>> n;
        endfunction

        function logic signed [19:0] map_row(input logic [63:0] row, input longint px,
                                             input longint py, inout bit clip);
            longint k0, k1, off, v;
            k0  = $signed(row[63:48]);
            k1  = $signed(row[47:32]);
            off = $signed(row[15:0]);
            v   = round_shift(k0 * px + k1 * py + (off <<< SH), SH);
            if (v > POINT_MAX) begin
                v    = POINT_MAX;
                clip = 1'b1;
            end
            if (v < POINT_MIN) begin
                v    = POINT_MIN;
                clip = 1'b1;
            end
            return v[19:0];
        endfunction

        function t_point transform_beam(t_beam b);
            longint cx, cy, cz, dx, dy, c, s, px, py;
            bit     clip;
            t_point p;
            if (b.first_beam)
                beam_angle = start_angle;
            else
                beam_angle = beam_angle + angle_step;
            cx = CORDIC_ONE_K;
            cy = 0;
            cz = longint'(beam_angle[13:0]) <<< 16;
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cz >= 0) begin
                    cx = cx - dx;
                    cy = cy + dy;
                    cz = cz - ATAN_TURNS[i];
                end else begin
                    cx = cx + dx;
                    cy = cy - dy;
                    cz = cz + ATAN_TURNS[i];
                end
            end
            case (beam_angle[15:14])
                2'd0: begin c = cx;  s = cy;  end
                2'd1: begin c = -cy; s = cx;  end
                2'd2: begin c = -cx; s = -cy; end
                default: begin c = cy; s = -cx; end
            endcase
            px   = round_shift(longint'(b.range_mm) * c, PX_SH);
            py   = round_shift(longint'(b.range_mm) * s, PX_SH);
            clip = 1'b0;
            p.x_mm            = map_row(rows[0], px, py, clip);
            p.y_mm            = map_row(rows[1], px, py, clip);
            p.z_mm            = map_row(rows[2], px, py, clip);
            p.point_intensity = b.intensity;
            p.scan_end        = b.last_beam;
            p.clipped         = clip;
            return p;
        endfunction

        function void note_beam(t_beam b);
            expected_points = {expected_points, transform_beam(b)};
        endfunction

        function void compare_field(string name, logic signed [63:0] want,
                                    logic signed [63:0] got);
            if (got !== want) begin
                mismatches++;
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_point(t_point got);
            t_point want;
            if (expected_points.size() == 0) begin
                mismatches++;
                $error("output beat with no pending point: x_mm %0d", got.x_mm);
                return;
            end
            want = expected_points.pop_front();
            compare_field("x_mm", want.x_mm, got.x_mm);
            compare_field("y_mm", want.y_mm, got.y_mm);
            compare_field("z_mm", want.z_mm, got.z_mm);
            compare_field("point_intensity", want.point_intensity, got.point_intensity);
            compare_field("scan_end", want.scan_end, got.scan_end);
            compare_field("clipped", want.clipped, got.clipped);
        endfunction

        function int unsigned pending();
            return expected_points.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_ready;
    logic [16:0]          range_mm   = '0;
    logic [15:0]          intensity  = '0;
    logic                 first_beam = 1'b0;
    logic                 last_beam  = 1'b0;
    logic                 out_valid;
    logic                 out_ready  = 1'b0;
    logic signed [19:0]   x_mm;
    logic signed [19:0]   y_mm;
    logic signed [19:0]   z_mm;
    logic [15:0]          point_intensity;
    logic                 scan_end;
    logic                 clipped;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [63:0]          cfg_data   = '0;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned hold_order    = 0;
    int unsigned hold_served   = 0;
    int unsigned hold_left     = 0;
    int unsigned quiet_cycles  = 0;

    point_scoreboard sb = new;

    scan_polar_to_cartesian_transform_unit i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_range_mm        (range_mm),
        .i_intensity       (intensity),
        .i_first_beam      (first_beam),
        .i_last_beam       (last_beam),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_x_mm            (x_mm),
        .o_y_mm            (y_mm),
        .o_z_mm            (z_mm),
        .o_point_intensity (point_intensity),
        .o_scan_end        (scan_end),
        .o_clipped         (clipped),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // output side: random stalls, plus a long hold on request
    always @(negedge clk) begin
        if (hold_served != hold_order) begin
            hold_served <= hold_order;
            hold_left   <= HOLD_CYCLES;
            out_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin : check_outputs
        t_point got;
        if (rst_n && out_valid && out_ready) begin
            got.x_mm            = x_mm;
            got.y_mm            = y_mm;
            got.z_mm            = z_mm;
            got.point_intensity = point_intensity;
            got.scan_end        = scan_end;
            got.clipped         = clipped;
            sb.check_point(got);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("** scan_polar_to_cartesian_transform_unit: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [16:0] pick_range();
        case ($urandom_range(7))
            0: return '0;
            1: return RANGE_MAX;
            2: return 17'($urandom_range(255));
            default: return 17'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h4000;
            3: return 16'hC000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_beam make_beam(bit first, bit last);
        t_beam b;
        b.range_mm   = pick_range();
        b.intensity  = 16'($urandom);
        b.first_beam = first;
        b.last_beam  = last;
        return b;
    endfunction

    // entered anywhere, returns at the posedge where the beat was taken
    task automatic send_beam(t_beam b);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        range_mm   <= b.range_mm;
        intensity  <= b.intensity;
        first_beam <= b.first_beam;
        last_beam  <= b.last_beam;
        do @(posedge clk); while (!in_ready);
        sb.note_beam(b);
    endtask

    task automatic stop_beams();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_register(idx, data);
    endtask

    task automatic stop_writes();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic set_idling(t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 80; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 80; end
            default:       begin send_idle_pct = 21; stall_pct = 21; end
        endcase
    endtask

    task automatic configure_phase(int unsigned phase);
        logic [63:0] row_vals [3];
        logic [15:0] start_val, step_val;
        if (phase == 0) begin
            row_vals  = '{ROW_X_RST, ROW_Y_RST, ROW_Z_RST};
            start_val = START_ANGLE_RST;
            step_val  = ANGLE_STEP_RST;
        end else if (phase == 1) begin
            row_vals  = '{3{64'h7FFF_7FFF_7FFF_7FFF}};
            start_val = '1;
            step_val  = '1;
        end else if (phase == 2) begin
            row_vals  = '{3{64'h8000_8000_8000_8000}};
            start_val = '0;
            step_val  = '0;
        end else begin
            for (int r = 0; r < 3; r++)
                row_vals[r] = {pick_coef(), pick_coef(), pick_coef(), pick_coef()};
            start_val = 16'($urandom);
            step_val  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 600));
        end
        write_reg(REG_ROW_X, row_vals[0]);
        write_reg(REG_ROW_Y, row_vals[1]);
        write_reg(REG_ROW_Z, row_vals[2]);
        write_reg(REG_START_ANGLE, {48'($urandom), start_val});
        write_reg(REG_ANGLE_STEP, {48'($urandom), step_val});
        write_reg(CFG_IDX_W'($urandom_range(REG_LAST_UNUSED, REG_FIRST_UNUSED)),
                  {$urandom, $urandom});
        stop_writes();
    endtask

    // mostly whole scans with random content, some stray beats with random markers
    task automatic run_scans(int unsigned n_beams);
        int unsigned sent, scan_len;
        sent = 0;
        while (sent < n_beams) begin
            if ($urandom_range(9) == 0) begin
                send_beam(make_beam($urandom_range(1), $urandom_range(1)));
                sent++;
            end else begin
                scan_len = $urandom_range(1, 24);
                for (int k = 0; k < scan_len && sent < n_beams; k++) begin
                    send_beam(make_beam(k == 0, k == scan_len - 1));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset transform; first beat has no first marker
        send_beam('{17'd1000, 16'h0001, 1'b0, 1'b0});
        send_beam('{17'd0, 16'h0000, 1'b1, 1'b0});
        send_beam('{RANGE_MAX, 16'hFFFF, 1'b0, 1'b1});
        send_beam('{17'd5000, 16'h5A5A, 1'b1, 1'b1});
        send_beam('{17'd1, 16'hA5A5, 1'b0, 1'b0});
        stop_beams();
        drain();

        // quarter-turn steps walk all quadrants and wrap
        write_reg(REG_ROW_X, 64'h7FFF_8000_7FFF_7FFF);
        write_reg(REG_ROW_Y, 64'h8000_7FFF_8000_8000);
        write_reg(REG_ROW_Z, 64'h4000_C000_1234_0001);
        write_reg(REG_START_ANGLE, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_ANGLE_STEP, 64'h0000_0000_0000_4000);
        write_reg(REG_LAST_UNUSED, 64'h0123_4567_89AB_CDEF);
        stop_writes();
        for (int k = 0; k < 8; k++)
            send_beam('{RANGE_MAX, 16'(k), k == 0, k == 7});
        stop_beams();
        drain();

        // backward step wraps below zero
        write_reg(REG_START_ANGLE, 64'h0);
        write_reg(REG_ANGLE_STEP, 64'hFFFF);
        stop_writes();
        for (int k = 0; k < 5; k++)
            send_beam('{17'($urandom_range(1, RANGE_MAX)), 16'($urandom), k == 0, 1'b0});

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            stop_beams();
            drain();
            set_idling(t_idle_mode'(phase % 4));
            configure_phase(phase);
            if (phase % 4 == 0) begin
                run_scans(PHASE_BEAMS / 3);
                hold_order++;
                run_scans(PHASE_BEAMS / 3);
                stop_beams();
                drain();
                run_scans(PHASE_BEAMS - 2 * (PHASE_BEAMS / 3));
            end else begin
                run_scans(PHASE_BEAMS);
            end
        end

        stop_beams();
        set_idling(IDLE_NONE);
        drain();
        repeat (4 * LATENCY) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("** scan_polar_to_cartesian_transform_unit: PASSED **");
        else
            $display("** scan_polar_to_cartesian_transform_unit: FAILED **");
        $finish;
    end

endmodule
